### src/crpe_pkg.sv
//------------------------------------------------------------------------------
// crpe_pkg
// types, constants and command structs shared by the path evaluator modules
//------------------------------------------------------------------------------
package crpe_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [2:0] MODE_CLEAR   = 3'd0;
    localparam logic [2:0] MODE_APPEND  = 3'd1;
    localparam logic [2:0] MODE_POS     = 3'd2;
    localparam logic [2:0] MODE_TAN     = 3'd3;
    localparam logic [2:0] MODE_READ    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DEFAULT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_IDX,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_COEF,
        S_MUL,
        S_ACC,
        S_FIN,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       load;     // capture input beat
        logic       prep;     // clamp / start wrap of t
        logic       div_step; // one restoring division step
        logic       idx;      // compute four indices
        logic [1:0] rd_sel;   // which control point to read
        logic       rd_en;
        logic       rd_cap;   // capture previous read
        logic       coef;     // form coefficients
        logic       mul;      // register products
        logic       acc;      // add and round
        logic       fin;      // final halving and result
        logic       direct;   // result without evaluation
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       div_done;
        logic       horner_last;
        logic       need_eval;
        logic       need_div;
    } t_sts;

endpackage

### src/crpe_ctrl.sv
//------------------------------------------------------------------------------
// crpe_ctrl
// sequencer for one item: division, four point reads, horner steps
//------------------------------------------------------------------------------
module crpe_ctrl
    import crpe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall_in,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_PREP;
            S_PREP: begin
                if (!i_sts.need_eval) n_state = S_OUT;
                else if (i_sts.need_div) n_state = S_DIV;
                else n_state = S_IDX;
            end
            S_DIV:  if (i_sts.div_done) n_state = S_IDX;
            S_IDX:  n_state = S_RD0;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_RD3;
            S_RD3:  n_state = S_COEF;
            S_COEF: n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = i_sts.horner_last ? S_FIN : S_MUL;
            S_FIN:  n_state = S_OUT;
            S_OUT:  if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_stall_in = (r_state != S_IDLE);
        o_valid    = (r_state == S_OUT);
        case (r_state)
            S_IDLE: o_cmd.load = i_valid;
            S_PREP: begin
                o_cmd.prep   = 1'b1;
                o_cmd.direct = !i_sts.need_eval;
            end
            S_DIV:  o_cmd.div_step = 1'b1;
            S_IDX:  o_cmd.idx = 1'b1;
            S_RD0: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_sel = 2'd0;
            end
            S_RD1: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_sel = 2'd1; o_cmd.rd_cap = 1'b1;
            end
            S_RD2: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_sel = 2'd2; o_cmd.rd_cap = 1'b1;
            end
            S_RD3: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_sel = 2'd3; o_cmd.rd_cap = 1'b1;
            end
            S_COEF: o_cmd.coef = 1'b1;
            S_MUL:  o_cmd.mul = 1'b1;
            S_ACC:  o_cmd.acc = 1'b1;
            S_FIN:  o_cmd.fin = 1'b1;
            S_OUT:  ;
            default: ;
        endcase
    end

endmodule

### src/crpe_datapath.sv
//------------------------------------------------------------------------------
// crpe_datapath
// point memory, parameter wrap divider, coefficient and horner datapath
//------------------------------------------------------------------------------
module crpe_datapath
    import crpe_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_loop_mode,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic signed [31:0] i_param_t,
    input  logic [6:0]         i_point_index,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic [6:0]         o_count_now,
    output logic [1:0]         o_status
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int MW = CW + FRAC_BITS;     // width of n * one
    localparam int DW = 33;                 // wrap dividend magnitude
    localparam int HW = 64;                 // horner accumulator
    localparam int DCW = $clog2(DW + 1);

    // ---------------- point memory ----------------
    logic [95:0] mem [MAX_POINTS];
    logic [95:0] r_rd_data;

    // ---------------- control registers ----------------
    logic [CW-1:0] r_total;
    logic [2:0]    r_mode;
    logic signed [31:0] r_t;
    logic [6:0]    r_pidx;
    logic signed [HW-1:0] r_res [3];
    logic [1:0]    r_status;
    logic          r_appended;

    logic [CW-1:0] total_m1;
    assign total_m1 = r_total - CW'(1);

    // memory write on append, read for evaluation and read mode
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    assign wr_en   = i_cmd.load && (i_mode == MODE_APPEND) && (r_total < CW'(MAX_POINTS));
    assign wr_addr = r_total[AW-1:0];

    // on the input beat the read address follows the new item, so the
    // direct cases find their point in the read register on the following cycle
    logic [AW-1:0] r_idx [4];
    logic [AW-1:0] rd_addr;
    always_comb begin
        if (i_cmd.rd_en) rd_addr = r_idx[i_cmd.rd_sel];
        else if (i_cmd.load) rd_addr = (i_mode == MODE_READ) ? AW'(i_point_index) : '0;
        else if (r_mode == MODE_READ) rd_addr = AW'(r_pidx);
        else rd_addr = '0;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= {i_coord_x, i_coord_y, i_coord_z};
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.load) begin
            if (i_mode == MODE_CLEAR) r_total <= '0;
            else if (wr_en) r_total <= r_total + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_t    <= i_param_t;
            r_pidx <= i_point_index;
        end
    end

    // ---------------- parameter wrap / clamp ----------------
    logic need_eval, need_div;
    assign need_eval = ((r_mode == MODE_POS) && (r_total >= CW'(2)))
                    || ((r_mode == MODE_TAN) && (r_total >= CW'(2)));
    assign need_div  = i_loop_mode;

    logic [MW-1:0] mod_m;
    assign mod_m = {r_total, {FRAC_BITS{1'b0}}};

    // restoring division of |t| by n*one, remainder only
    logic [DW-1:0]  r_dq;     // shifting dividend
    logic [MW:0]    r_rem;
    logic [DCW-1:0] r_dcnt;
    logic           r_tneg;
    logic [MW:0]    rem_sh, rem_sub;
    assign rem_sh  = {r_rem[MW-1:0], r_dq[DW-1]};
    assign rem_sub = rem_sh - {1'b0, mod_m};

    logic signed [33:0] t_ext;
    assign t_ext = 34'(r_t);

    // clamped / wrapped parameter in [0, n*one)
    logic [MW-1:0] r_tw;
    logic [MW-1:0] clamp_max;
    assign clamp_max = {total_m1, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_tneg <= r_t[31];
            r_dq   <= r_t[31] ? DW'(-t_ext) : DW'(t_ext);
            r_rem  <= '0;
            r_dcnt <= DCW'(DW);
            if (r_t[31]) r_tw <= '0;
            else if ({2'b0, r_t} > 34'(clamp_max)) r_tw <= clamp_max;
            else r_tw <= MW'(r_t);
        end else if (i_cmd.div_step) begin
            r_dq   <= {r_dq[DW-2:0], 1'b0};
            r_dcnt <= r_dcnt - DCW'(1);
            if (!rem_sub[MW]) r_rem <= rem_sub;
            else r_rem <= rem_sh;
            if (r_dcnt == DCW'(1)) begin
                // final remainder, fold negative dividends
                if (!rem_sub[MW]) begin
                    r_tw <= (r_tneg && rem_sub[MW-1:0] != '0) ?
                            mod_m - rem_sub[MW-1:0] : rem_sub[MW-1:0];
                end else begin
                    r_tw <= (r_tneg && rem_sh[MW-1:0] != '0) ?
                            mod_m - rem_sh[MW-1:0] : rem_sh[MW-1:0];
                end
            end
        end
    end

    // ---------------- indices ----------------
    logic [CW-1:0] seg;
    logic          f_one;
    assign seg   = r_tw[MW-1:FRAC_BITS];
    assign f_one = !i_loop_mode && (seg >= total_m1);

    logic [FRAC_BITS:0] r_f;
    logic [CW-1:0] seg_eff;
    assign seg_eff = f_one ? (r_total - CW'(2)) : seg;

    function automatic logic [AW-1:0] wrap_idx(input logic [CW+1:0] i,
                                               input logic [CW-1:0] n,
                                               input logic lp);
        logic signed [CW+1:0] s;
        logic signed [CW+1:0] r;
        begin
            s = $signed(i) - (CW+2)'(1);
            if (lp) begin
                r = s;
                if (r < 0) r = r + $signed({2'b0, n});
                else if (r >= $signed({2'b0, n})) r = r - $signed({2'b0, n});
            end else begin
                r = s;
                if (r < 0) r = '0;
                else if (r >= $signed({2'b0, n})) r = $signed({2'b0, n}) - (CW+2)'(1);
            end
            wrap_idx = r[AW-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx) begin
            r_f <= f_one ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, r_tw[FRAC_BITS-1:0]};
            for (int k = 0; k < 4; k++) begin
                // index offset k - 1, biased by one to stay unsigned
                r_idx[k] <= wrap_idx((CW+2)'(seg_eff) + (CW+2)'(k), r_total, i_loop_mode);
            end
        end
    end

    // ---------------- capture control points ----------------
    // the last point is taken straight from the read register
    logic signed [31:0] r_p [3][3];
    logic [1:0] cap_sel;
    assign cap_sel = i_cmd.rd_sel - 2'd1;   // read data belongs to the previous select
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_cap) begin
            r_p[cap_sel][0] <= r_rd_data[95:64];
            r_p[cap_sel][1] <= r_rd_data[63:32];
            r_p[cap_sel][2] <= r_rd_data[31:0];
        end
    end

    // ---------------- coefficients and horner ----------------
    logic signed [HW-1:0] r_a [3][3];
    logic signed [HW-1:0] r_h [3];
    logic signed [HW-1:0] r_prod [3];
    logic [1:0] r_step;
    logic       tan;
    assign tan = (r_mode == MODE_TAN);

    logic signed [HW-1:0] p0 [3], p1 [3], p2 [3], p3n [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            p0[c]  = HW'(r_p[0][c]);
            p1[c]  = HW'(r_p[1][c]);
            p2[c]  = HW'(r_p[2][c]);
            p3n[c] = HW'($signed(r_rd_data[95-32*c -: 32]));
        end
    end

    // h is bounded to about 36 bits and f to 17, so a 38x18 product suffices
    logic signed [HW-1:0] rnd;
    assign rnd = HW'(1) <<< (FRAC_BITS - 1);
    assign o_sts.horner_last = tan ? (r_step == 2'd1) : (r_step == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef) begin
            r_step <= '0;
            for (int c = 0; c < 3; c++) begin
                r_a[0][c] <= p1[c] <<< 1;
                r_a[1][c] <= p2[c] - p0[c];
                r_a[2][c] <= (p0[c] <<< 1) - 5 * p1[c] + (p2[c] <<< 2) - p3n[c];
                r_h[c]    <= tan ? 3 * (-p0[c] + 3 * p1[c] - 3 * p2[c] + p3n[c])
                                 : (-p0[c] + 3 * p1[c] - 3 * p2[c] + p3n[c]);
            end
        end else if (i_cmd.mul) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= HW'($signed(r_h[c][37:0]) * $signed({1'b0, r_f}));
            end
        end else if (i_cmd.acc) begin
            r_step <= r_step + 2'd1;
            for (int c = 0; c < 3; c++) begin
                case (r_step)
                    2'd0: r_h[c] <= (tan ? (r_a[2][c] <<< 1) : r_a[2][c])
                                  + ((r_prod[c] + rnd) >>> FRAC_BITS);
                    2'd1: r_h[c] <= r_a[1][c] + ((r_prod[c] + rnd) >>> FRAC_BITS);
                    default: r_h[c] <= r_a[0][c] + ((r_prod[c] + rnd) >>> FRAC_BITS);
                endcase
            end
        end
    end

    // ---------------- result ----------------
    logic in_range;
    assign in_range = (32'(r_pidx) < 32'(r_total)) && (32'(r_pidx) < 32'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_status <= ST_OK;
            for (int c = 0; c < 3; c++) r_res[c] <= (r_h[c] + HW'(1)) >>> 1;
        end else if (i_cmd.direct) begin
            r_status <= ST_OK;
            for (int c = 0; c < 3; c++) r_res[c] <= '0;
            case (r_mode)
                MODE_APPEND: if (r_total == CW'(MAX_POINTS) && !r_appended) r_status <= ST_FULL;
                MODE_POS: begin
                    if (r_total == '0) r_status <= ST_DEFAULT;
                    else for (int c = 0; c < 3; c++)
                        r_res[c] <= HW'($signed(r_rd_data[95-32*c -: 32]));
                end
                MODE_TAN: begin
                    r_status <= ST_DEFAULT;
                    r_res[2] <= HW'(1) <<< FRAC_BITS;
                end
                MODE_READ: begin
                    if (!in_range) r_status <= ST_DEFAULT;
                    else for (int c = 0; c < 3; c++)
                        r_res[c] <= HW'($signed(r_rd_data[95-32*c -: 32]));
                end
                default: ;
            endcase
        end
    end

    // remember whether the append went in
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_appended <= wr_en;
    end

    function automatic logic signed [31:0] sat(input logic signed [HW-1:0] v);
        if (v > HW'(32'sh7fffffff)) sat = 32'sh7fffffff;
        else if (v < -HW'(64'sh80000000)) sat = 32'sh80000000;
        else sat = v[31:0];
    endfunction

    assign o_out_x     = sat(r_res[0]);
    assign o_out_y     = sat(r_res[1]);
    assign o_out_z     = sat(r_res[2]);
    assign o_count_now = 7'(r_total);
    assign o_status    = r_status;

    assign o_sts.div_done  = (r_dcnt == DCW'(1));
    assign o_sts.need_eval = need_eval;
    assign o_sts.need_div  = need_div;

endmodule

### src/catmull_rom_path_evaluator.sv
//------------------------------------------------------------------------------
// catmull_rom_path_evaluator
// uniform catmull-rom path over a table of 3d control points
//------------------------------------------------------------------------------
// One item at a time. Clear, append, read and the degenerate cases go from
// the input beat through a prepare step to the output beat. An evaluation in
// open mode clamps the parameter; in loop mode the parameter is first
// wrapped by a restoring divider, one bit per cycle. Then come four
// single-port reads of the point memory and two (tangent) or three (position)
// horner multiply/add steps before the output beat. Output stalls hold the
// output beat.
module catmull_rom_path_evaluator
    import crpe_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic signed [31:0] i_param_t,
    input  logic [6:0]         i_point_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic [6:0]         o_count_now,
    output logic [1:0]         o_status
);

    logic r_loop_mode;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_loop_mode <= i_cfg_data;
        end
    end

    crpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall_in (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    crpe_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_loop_mode   (r_loop_mode),
        .i_mode        (i_mode),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_param_t     (i_param_t),
        .i_point_index (i_point_index),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_count_now   (o_count_now),
        .o_status      (o_status)
    );

    // no input taken while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken during output");

    // an accepted beat leads to busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall) else $error("not busy after accept");

    // count never exceeds table depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_count_now) <= 32'(MAX_POINTS))) else $error("count too large");

endmodule
